>>> src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

	// Queue size and derived widths
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

	// Command codes
	localparam logic [2:0] CMD_NONE       = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_POP_BACK   = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic signed [DATA_W-1:0] EMPTY_POP_VALUE = -32'sd1;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [DATA_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic [1:0]               status;
		logic [CNT_W-1:0]         entry_count;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
	} out_item_t;

	// Per-cycle control broadcast to every cell
	typedef struct packed {
		logic             push_front;
		logic             pop_front;
		logic             push_back;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/deq_cell.sv
// One storage cell of the queue row: holds one entry and shifts with its neighbors.
`default_nettype none

module deq_cell
	import deq_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire                             clk,
	input  wire cell_ctrl_t                 ctrl,
	input  wire logic signed [DATA_W-1:0]   push_value,
	input  wire logic signed [DATA_W-1:0]   left_data,
	input  wire logic signed [DATA_W-1:0]   right_data,
	output logic signed [DATA_W-1:0]        data_q,
	output logic signed [DATA_W-1:0]        data_d
);

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

	// Pick next entry: shift toward back, shift toward front, load at tail, or hold
	always_comb begin
		data_d = data_q;
		if (ctrl.push_front) begin
			data_d = left_data;
		end else if (ctrl.pop_front) begin
			data_d = right_data;
		end else if (ctrl.push_back && ctrl.count == MY_POS) begin
			data_d = push_value;
		end
	end

	// Hold entry
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

`default_nettype wire

>>> src/double_ended_queue_core.sv
// Top level of the double-ended queue built as a row of shifting cells.
//
// Usage:
//   Input channel (in_valid / in_ready / in_item) carries a command and a value:
//   none, push front, push back, pop front, pop back. Every accepted item
//   yields exactly one result on the output channel (out_valid / out_ready /
//   out_item): popped value, status, entry count and the front and back
//   entries after the command.
//   Entries sit in a row of DEPTH cells with the front in cell 0. A front push
//   shifts the whole row one cell back, a front pop shifts it one cell
//   forward, a back push loads the cell at the current count. All of it
//   happens in the cycle the item is accepted.
//   The result is registered and valid in the cycle after acceptance.
//   Throughput: one item per cycle while the receiver takes each result,
//   bounded by the cell update and the output register.
//   A stalled receiver holds the result register; in_ready stays high only
//   while that register is empty or being taken in the same cycle.
//   Reset empties the queue (entry count cleared) and drops any pending
//   result; the cells themselves are not cleared.
`default_nettype none

module double_ended_queue_core
	import deq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire in_item_t in_item,
	output logic       out_valid,
	input  wire        out_ready,
	output out_item_t  out_item
);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     out_valid_q;
	out_item_t                out_q;
	out_item_t                out_d;
	cell_ctrl_t               ctrl;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [1:0]               status_d;
	logic signed [DATA_W-1:0] popped_d;
	logic [CNT_W-1:0]         last_old;
	logic [CNT_W-1:0]         last_new;
	logic signed [DATA_W-1:0] back_old;
	logic signed [DATA_W-1:0] back_new;

	logic signed [DATA_W-1:0] cell_q [DEPTH];
	logic signed [DATA_W-1:0] cell_d [DEPTH];

	// Handshake
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign full  = (count_q == FULL_COUNT);
	assign empty = (count_q == '0);

	// Decode command into cell control, status and new count
	always_comb begin
		ctrl       = '0;
		ctrl.count = count_q;
		status_d   = ST_OK;
		popped_d   = '0;
		count_d    = count_q;
		unique case (in_item.command)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.push_front = accept;
					count_d         = count_q + CNT_W'(1);
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.push_back = accept;
					count_d        = count_q + CNT_W'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
					popped_d = EMPTY_POP_VALUE;
				end else begin
					ctrl.pop_front = accept;
					popped_d       = cell_q[0];
					count_d        = count_q - CNT_W'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
					popped_d = EMPTY_POP_VALUE;
				end else begin
					popped_d = back_old;
					count_d  = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Select the tail entry before and after the command
	assign last_old = count_q - CNT_W'(1);
	assign last_new = count_d - CNT_W'(1);
	assign back_old = cell_q[last_old[IDX_W-1:0]];
	assign back_new = cell_d[last_new[IDX_W-1:0]];

	// Build result
	always_comb begin
		out_d.popped_value = popped_d;
		out_d.status       = status_d;
		out_d.entry_count  = count_d;
		if (count_d == '0) begin
			out_d.front_value = '0;
			out_d.back_value  = '0;
		end else begin
			out_d.front_value = cell_d[0];
			out_d.back_value  = back_new;
		end
	end

	// Row of cells; cell 0 takes the pushed value on a front push
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_data;
		logic signed [DATA_W-1:0] right_data;

		if (i == 0) begin : g_head
			assign left_data = in_item.push_value;
		end else begin : g_body
			assign left_data = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_data = cell_q[i];
		end else begin : g_inner
			assign right_data = cell_q[i+1];
		end

		deq_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.push_value (in_item.push_value),
			.left_data  (left_data),
			.right_data (right_data),
			.data_q     (cell_q[i]),
			.data_d     (cell_d[i])
		);
	end

	// Advance count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= out_d;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count exceeds depth");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.entry_count == count_q)
		else $error("reported count differs from stored count");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_FULL |-> out_q.entry_count == FULL_COUNT)
		else $error("push dropped while queue not full");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_EMPTY
		|-> out_q.entry_count == '0 && out_q.popped_value == EMPTY_POP_VALUE)
		else $error("empty pop reported wrongly");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.entry_count == '0
		|-> out_q.front_value == '0 && out_q.back_value == '0)
		else $error("empty queue shows nonzero ends");

	a_none_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.command == CMD_NONE |=> count_q == $past(count_q))
		else $error("idle command changed count");
`endif

endmodule

`default_nettype wire

>>> test/deq_result_checker.sv
// Result checker for the double-ended queue: tracks the queue contents and compares every result.
`default_nettype none

module deq_result_checker
	import deq_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	input  wire       in_ready,
	input  wire in_item_t  in_item,
	input  wire       out_valid,
	input  wire       out_ready,
	input  wire out_item_t out_item,
	output int        failures,
	output int        pending,
	output int        results_checked,
	output int        dropped_pushes,
	output int        empty_pops
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the queue
	logic signed [DATA_W-1:0] shadow_entries [DEPTH];
	int unsigned              head_slot;
	int unsigned              tail_slot;
	logic [CNT_W-1:0]         shadow_count;

	out_item_t awaited_results [$];

	initial begin
		failures = 0;
		results_checked = 0;
		dropped_pushes = 0;
		empty_pops = 0;
		pending = 0;
	end

	// Apply one command to the shadow queue and return the result it should give
	function automatic out_item_t apply_command(in_item_t item);
		out_item_t r;
		r = '0;
		case (item.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (shadow_count == FULL_COUNT) begin
					r.status = ST_FULL;
				end else if (item.command == CMD_PUSH_FRONT) begin
					head_slot = (head_slot + DEPTH - 1) % DEPTH;
					shadow_entries[head_slot] = item.push_value;
					shadow_count = shadow_count + 1'b1;
				end else begin
					shadow_entries[tail_slot] = item.push_value;
					tail_slot = (tail_slot + 1) % DEPTH;
					shadow_count = shadow_count + 1'b1;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (shadow_count == '0) begin
					r.popped_value = EMPTY_POP_VALUE;
					r.status = ST_EMPTY;
				end else if (item.command == CMD_POP_FRONT) begin
					r.popped_value = shadow_entries[head_slot];
					head_slot = (head_slot + 1) % DEPTH;
					shadow_count = shadow_count - 1'b1;
				end else begin
					tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
					r.popped_value = shadow_entries[tail_slot];
					shadow_count = shadow_count - 1'b1;
				end
			end
			default: ;
		endcase
		r.entry_count = shadow_count;
		if (shadow_count != '0) begin
			r.front_value = shadow_entries[head_slot];
			r.back_value = shadow_entries[(tail_slot + DEPTH - 1) % DEPTH];
		end
		return r;
	endfunction

	task automatic compare_field(string field, logic signed [DATA_W-1:0] want,
			logic signed [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			failures++;
		end
	endtask

	// Watch both channels: check results first, then queue up the new expectation
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			head_slot = 0;
			tail_slot = 0;
			shadow_count = '0;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result arrived with no command outstanding");
					failures++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("popped_value", want.popped_value, out_item.popped_value);
					compare_field("status", want.status, out_item.status);
					compare_field("entry_count", want.entry_count, out_item.entry_count);
					compare_field("front_value", want.front_value, out_item.front_value);
					compare_field("back_value", want.back_value, out_item.back_value);
					results_checked++;
					if (want.status == ST_FULL)
						dropped_pushes++;
					if (want.status == ST_EMPTY)
						empty_pops++;
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(apply_command(in_item));
			pending <= awaited_results.size();
		end
	end

endmodule

`default_nettype wire

>>> test/tb_double_ended_queue_core.sv
// Testbench top for the double-ended queue: clock, reset, command stimulus and verdict.
`default_nettype none

module tb_double_ended_queue_core
	import deq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_TAIL    = 80;
	localparam int HOLD_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 200_000;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_item_t  in_item   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_item;

	int failures;
	int pending;
	int results_checked;
	int dropped_pushes;
	int empty_pops;

	bit idling_on    = 1'b1;
	bit hold_request = 1'b0;
	int commands_sent = 0;
	int cycle_count   = 0;

	double_ended_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	deq_result_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_item         (in_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_item        (out_item),
		.failures        (failures),
		.pending         (pending),
		.results_checked (results_checked),
		.dropped_pushes  (dropped_pushes),
		.empty_pops      (empty_pops)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result receiver: random stall bursts, plus one long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Present one item, after an optional idle burst, and hold it until accepted
	task automatic offer(logic [2:0] cmd, logic signed [DATA_W-1:0] value);
		int gap;
		gap = 0;
		if (idling_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{command: cmd, push_value: value};
		do @(posedge clk); while (!in_ready);
		commands_sent++;
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [2:0] pick_command(int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return 3'($urandom_range(0, 7));
		if (roll < 6 + push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return -32'sd1;
			3:       return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// Stimulus and verdict
	initial begin
		int  random_sent;
		int  seg_len;
		int  push_pct;
		bit  hold_done;
		bit  pause_done;
		random_sent = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Pops on an empty queue, then commands that leave the queue alone
		offer(CMD_POP_FRONT, 32'sd5);
		offer(CMD_POP_BACK, -32'sd7);
		offer(CMD_NONE, 32'sh7FFF_FFFF);
		for (int c = CMD_POP_BACK + 1; c < 8; c++)
			offer(3'(c), $urandom);

		// Fill from both ends with extreme values first; front pushes wrap the index
		for (int i = 0; i < DEPTH; i++)
			offer(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
				(i < 4) ? ((i == 0) ? 32'sh7FFF_FFFF : (i == 1) ? 32'sh8000_0000 :
				(i == 2) ? -32'sd1 : 32'sd0) : $urandom);

		// Pushes onto a full queue, then one pop from each end
		offer(CMD_PUSH_FRONT, 32'sh1234_5678);
		offer(CMD_PUSH_BACK, -32'sd2);
		offer(CMD_POP_FRONT, 32'sd0);
		offer(CMD_POP_BACK, 32'sd0);

		// Random segments that lean toward filling, draining or neither
		while (random_sent < RANDOM_ITEMS) begin
			if (!hold_done && random_sent >= 100) begin
				// Keep offering while the receiver holds off
				hold_done = 1'b1;
				idling_on = 1'b0;
				hold_request = 1'b1;
				repeat (20) offer(pick_command(50), pick_value());
				random_sent += 20;
				idling_on = 1'b1;
			end
			if (!pause_done && random_sent >= 220) begin
				pause_done = 1'b1;
				drain();
			end
			if (random_sent >= RANDOM_ITEMS - CALM_TAIL)
				idling_on = 1'b0;
			seg_len = $urandom_range(10, 40);
			case ($urandom_range(0, 2))
				0:       push_pct = 75;
				1:       push_pct = 20;
				default: push_pct = 47;
			endcase
			repeat (seg_len) begin
				offer(pick_command(push_pct), pick_value());
				random_sent++;
			end
		end

		drain();
		repeat (4) @(posedge clk);

		$display("Sent %0d commands and checked %0d results.", commands_sent, results_checked);
		$display("Saw %0d pushes dropped on a full queue and %0d pops on an empty one.",
			dropped_pushes, empty_pops);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
src/deq_pkg.sv
src/deq_cell.sv
src/double_ended_queue_core.sv
test/deq_result_checker.sv
test/tb_double_ended_queue_core.sv
